### design/lpm_pkg.sv
package lpm_pkg;

  // defaults of the top level parameters
  localparam int PHASE_BITS_DEF = 24;
  localparam int SINE_DEPTH_DEF = 256;
  localparam int MAX_ARP_DEF    = 8;

  localparam logic [23:0] FMAX = 24'hFF_FFFF;

  // pi/2 and ln2 in Q30
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [31:0] LN2_Q30     = 32'd744261118;

  localparam logic [63:0] TWO_32 = 64'h1_0000_0000;

  // exponent divisors: cents to Q16 octaves, semitones to Q16 octaves
  localparam logic [9:0]  DIV_EXP   = 10'd600;
  localparam logic [9:0]  DIV_ARP   = 10'd12;
  localparam logic [31:0] RECIP_EXP = 32'(TWO_32 / 600);
  localparam logic [31:0] RECIP_ARP = 32'(TWO_32 / 12);

  // floor(2^32 / k) for series terms k = 1..10, k = 1 held at 2^32 - 1
  localparam logic [3:0]  TERM_LAST = 4'd9;
  localparam logic [31:0] RECIP_TERM [10] = '{
    32'hFFFF_FFFF,        32'h8000_0000,        32'(TWO_32 / 3),
    32'h4000_0000,        32'(TWO_32 / 5),      32'(TWO_32 / 6),
    32'(TWO_32 / 7),      32'h2000_0000,        32'(TWO_32 / 9),
    32'(TWO_32 / 10)
  };

  // sine series denominators (2k)(2k+1)
  localparam logic [63:0] TAYLOR_DIV [6] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
  };

  typedef enum logic [2:0] {
    CFG_RATE,
    CFG_OFFSET,
    CFG_WAVE,
    CFG_PULSE,
    CFG_MODE,
    CFG_DEPTH,
    CFG_ARP_OFS,
    CFG_ARP_CNT
  } lpm_cfg_idx_e;

  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SAW_UP = 3'd1;
  localparam logic [2:0] WAVE_SAW_DN = 3'd2;
  localparam logic [2:0] WAVE_TRI    = 3'd3;
  localparam logic [2:0] WAVE_RECT   = 3'd4;

  localparam logic [1:0] MODE_EXP = 2'd0;
  localparam logic [1:0] MODE_LIN = 2'd1;
  localparam logic [1:0] MODE_ARP = 2'd2;

  typedef struct packed {
    logic [23:0] rate_increment;
    logic [23:0] phase_offset;
    logic [2:0]  waveform;
    logic [23:0] pulse_width;
    logic [1:0]  mod_mode;
    logic [13:0] depth;
    logic [63:0] arp_offsets;
    logic [3:0]  arp_count;
  } lpm_cfg_t;

  // quarter sine entry in Q15 from an angle in Q30, evaluated at elaboration
  function automatic logic [14:0] sine_q15(input logic [63:0] x);
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        q;
    logic [14:0]        res;
    t = x;
    s = $signed(x);
    for (int k = 0; k < 6; k++) begin
      t = ((((t * x) >> 30) * x) >> 30) / TAYLOR_DIV[k];
      if (k[0] == 1'b0) begin
        s = s - $signed(t);
      end else begin
        s = s + $signed(t);
      end
    end
    if (s <= 0) begin
      res = '0;
    end else begin
      q = (64'(s) + 64'd16384) >> 15;
      res = (q > 64'd32767) ? 15'h7FFF : q[14:0];
    end
    return res;
  endfunction

endpackage

### design/lpm_cfg_regs.sv
module lpm_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  output lpm_pkg::lpm_cfg_t cfg_o
);
  import lpm_pkg::*;

  lpm_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_increment <= '0;
      cfg_q.phase_offset   <= '0;
      cfg_q.waveform       <= '0;
      cfg_q.pulse_width    <= 24'h80_0000;
      cfg_q.mod_mode       <= '0;
      cfg_q.depth          <= '0;
      cfg_q.arp_offsets    <= '0;
      cfg_q.arp_count      <= 4'd1;
    end else if (cfg_valid_i) begin
      case (lpm_cfg_idx_e'(cfg_index_i))
        CFG_RATE:    cfg_q.rate_increment <= cfg_data_i[23:0];
        CFG_OFFSET:  cfg_q.phase_offset   <= cfg_data_i[23:0];
        CFG_WAVE:    cfg_q.waveform       <= cfg_data_i[2:0];
        CFG_PULSE:   cfg_q.pulse_width    <= cfg_data_i[23:0];
        CFG_MODE:    cfg_q.mod_mode       <= cfg_data_i[1:0];
        CFG_DEPTH:   cfg_q.depth          <= cfg_data_i[13:0];
        CFG_ARP_OFS: cfg_q.arp_offsets    <= cfg_data_i;
        CFG_ARP_CNT: cfg_q.arp_count      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

endmodule

### design/lpm_mul.sv
module lpm_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

endmodule

### design/lpm_sine_rom.sv
module lpm_sine_rom #(
  parameter int SINE_TABLE_DEPTH = lpm_pkg::SINE_DEPTH_DEF,
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic [AW-1:0] addr_i,
  output logic [14:0]   data_o
);
  import lpm_pkg::*;

  logic [14:0] rom [SINE_TABLE_DEPTH + 1];
  logic [14:0] data_q;

  // quarter wave, one entry past the end for the exact peak
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] ANGLE = (64'(g) * PI_HALF_Q30) / 64'(SINE_TABLE_DEPTH);
    assign rom[g] = sine_q15(ANGLE);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

### design/lfo_pitch_modulator.sv
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | base_freq_i
// out     | output    | out_valid_o / out_ready_i | mod_freq_o, wave_value_o, phase_now_o,
//         |           |                           | saturated_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word at a time: linear and pass-through modes finish in the ST_DISP state,
// exponential and arpeggio modes go on through the divide and a 2^x series of ten terms
// after the leading one, each term stepped through the single shared 32x32 multiplier.
// in_ready_o is high only while the sequencer is idle, so the next word can be taken in
// the cycle after the result is loaded; a finished word waits in the last state while the
// output register still holds an unaccepted word. cfg_ready_o is always high.
// reset clears the phase accumulator and loads the register defaults.
module lfo_pitch_modulator #(
  parameter int PHASE_BITS       = lpm_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = lpm_pkg::SINE_DEPTH_DEF,
  parameter int MAX_ARP_STEPS    = lpm_pkg::MAX_ARP_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [23:0]        base_freq_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        mod_freq_o,
  output logic signed [15:0] wave_value_o,
  output logic [23:0]        phase_now_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);
  import lpm_pkg::*;

  localparam int AW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int FSH = 32 - PHASE_BITS;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IDX,
    ST_ROM,
    ST_WAVE,
    ST_DW,
    ST_DISP,
    ST_DIV1,
    ST_DIV2,
    ST_DIV3,
    ST_Y,
    ST_YL,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_BASE,
    ST_SCALE,
    ST_DONE
  } state_e;

  lpm_cfg_t cfg;

  state_e                  state_q;
  logic [PHASE_BITS-1:0]   acc_q;
  logic [PHASE_BITS-1:0]   phase_q;
  logic [23:0]             base_q;
  logic signed [15:0]      w_q;
  logic [7:0]              s_q;
  logic                    a_neg_q;
  logic [28:0]             a_mag_q;
  logic [31:0]             q_q;
  logic [5:0]              n_q;
  logic [15:0]             fr_q;
  logic [29:0]             y_q;
  logic [31:0]             x_q;
  logic [30:0]             t_q;
  logic [31:0]             m_q;
  logic [3:0]              k_q;
  logic [23:0]             res_freq_q;
  logic                    res_sat_q;
  logic                    out_valid_q;
  logic [23:0]             mod_freq_q;
  logic [15:0]             wave_out_q;
  logic [23:0]             phase_out_q;
  logic                    sat_out_q;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [AW-1:0]     sin_idx, rom_addr;
  logic [14:0]       rom_data;
  logic [31:0]       f;
  logic [PHASE_BITS-1:0] phase_sum;

  lpm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lpm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  lpm_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign phase_sum = acc_q + PHASE_BITS'(cfg.phase_offset);
  // phase as a 32-bit cycle fraction
  assign f = 32'(phase_q) << FSH;

  // mirror the lookup in odd quadrants
  assign sin_idx  = mul_p[30 +: AW];
  assign rom_addr = f[30] ? AW'(SINE_TABLE_DEPTH) - sin_idx : sin_idx;

  // waveform
  logic signed [15:0] wave_d, sine_v;
  logic [16:0]        tri_q, tri_mid;
  always_comb begin
    sine_v  = $signed({1'b0, rom_data});
    tri_q   = f[31:15];
    tri_mid = 17'h1_0000 - tri_q;
    wave_d  = '0;
    case (cfg.waveform)
      WAVE_SINE:   wave_d = f[31] ? -sine_v : sine_v;
      WAVE_SAW_UP: wave_d = $signed({~f[31], f[30:16]});
      WAVE_SAW_DN: wave_d = (f[31:16] == 16'd0) ? 16'sh7FFF : $signed(16'h8000 - f[31:16]);
      WAVE_TRI: begin
        if (tri_q[16:15] == 2'b00) begin
          wave_d = $signed({1'b0, tri_q[14:0]});
        end else if (tri_q[16:15] != 2'b11) begin
          wave_d = (tri_q == 17'h0_8000) ? 16'sh7FFF : $signed(tri_mid[15:0]);
        end else begin
          wave_d = $signed(tri_q[15:0]);
        end
      end
      WAVE_RECT:   wave_d = (f < {cfg.pulse_width, 8'h00}) ? 16'sh7FFF : 16'sh8000;
      default:     wave_d = '0;
    endcase
  end

  // arpeggio step picked by floor(phase * count)
  logic [3:0]  arp_cnt;
  logic [35:0] arp_prod;
  logic [2:0]  arp_idx;
  logic [7:0]  arp_step;
  always_comb begin
    if (cfg.arp_count == 4'd0) begin
      arp_cnt = 4'd1;
    end else if (cfg.arp_count > 4'(MAX_ARP_STEPS)) begin
      arp_cnt = 4'(MAX_ARP_STEPS);
    end else begin
      arp_cnt = cfg.arp_count;
    end
    arp_prod = 36'(f) * 36'(arp_cnt);
    arp_idx  = arp_prod[34:32];
    arp_step = cfg.arp_offsets[{arp_idx, 3'b000} +: 8];
  end

  logic [13:0] d_mag;
  logic [15:0] w_mag;
  logic [7:0]  s_mag;
  logic [9:0]  div_k;
  logic [31:0] div_recip;
  assign d_mag     = cfg.depth[13] ? 14'(-cfg.depth) : cfg.depth;
  assign w_mag     = w_q[15] ? 16'(-w_q) : 16'(w_q);
  assign s_mag     = s_q[7] ? 8'(-s_q) : s_q;
  assign div_k     = (cfg.mod_mode == MODE_ARP) ? DIV_ARP : DIV_EXP;
  assign div_recip = (cfg.mod_mode == MODE_ARP) ? RECIP_ARP : RECIP_EXP;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_IDX: begin
        mul_a = {2'b00, f[29:0]};
        mul_b = 32'(SINE_TABLE_DEPTH);
      end
      ST_DW: begin
        if (cfg.mod_mode == MODE_ARP) begin
          mul_a = 32'(s_mag);
          mul_b = 32'h0001_0000;
        end else begin
          mul_a = 32'(d_mag);
          mul_b = 32'(w_mag);
        end
      end
      ST_DIV1: begin
        mul_a = 32'(a_mag_q);
        mul_b = div_recip;
      end
      ST_DIV2: begin
        mul_a = mul_p[63:32];
        mul_b = 32'(div_k);
      end
      ST_Y: begin
        mul_a = 32'(fr_q);
        mul_b = LN2_Q30;
      end
      ST_T1: begin
        mul_a = 32'(t_q);
        mul_b = 32'(y_q);
      end
      ST_T2: begin
        mul_a = mul_p[61:30];
        mul_b = RECIP_TERM[k_q];
      end
      ST_T3: begin
        mul_a = mul_p[63:32];
        mul_b = 32'(k_q) + 32'd1;
      end
      ST_BASE: begin
        mul_a = 32'(base_q);
        mul_b = m_q;
      end
      default: ;
    endcase
  end

  // linear mode: base + floor(depth * wave / 128)
  logic [29:0]        lin_a;
  logic signed [29:0] lin_s, lin_sh;
  logic signed [26:0] lin_r;
  logic [23:0]        lin_freq;
  logic               lin_sat;
  always_comb begin
    lin_a  = {1'b0, mul_p[28:0]};
    lin_s  = a_neg_q ? -$signed(lin_a) : $signed(lin_a);
    lin_sh = lin_s >>> 7;
    lin_r  = $signed({3'b000, base_q}) + $signed(lin_sh[26:0]);
    if (lin_r[26]) begin
      lin_freq = '0;
      lin_sat  = 1'b1;
    end else if (lin_r[25:24] != 2'b00) begin
      lin_freq = FMAX;
      lin_sat  = 1'b1;
    end else begin
      lin_freq = lin_r[23:0];
      lin_sat  = 1'b0;
    end
  end

  // correction step of the reciprocal divide, then floor for negatives
  logic [31:0]        div_r;
  logic               div_ge, div_rem_nz;
  logic [20:0]        div_q, div_q_up;
  logic signed [21:0] e16;
  always_comb begin
    div_r      = 32'(a_mag_q) - mul_p[31:0];
    div_ge     = div_r >= 32'(div_k);
    div_rem_nz = div_ge ? (div_r != 32'(div_k)) : (div_r != 32'd0);
    div_q      = q_q[20:0] + 21'(div_ge);
    div_q_up   = div_q + 21'(div_rem_nz);
    e16        = a_neg_q ? -$signed({1'b0, div_q_up}) : $signed({1'b0, div_q});
  end

  // series term: floor(x / k)
  logic [31:0] term_r, term_q;
  always_comb begin
    term_r = x_q - mul_p[31:0];
    term_q = q_q + 32'(term_r >= (32'(k_q) + 32'd1));
  end

  // base * mantissa * 2^n, rounded half up
  logic signed [6:0] sh;
  logic [5:0]        sh_u;
  logic [63:0]       rnd, scale_v;
  logic [23:0]       scale_freq;
  logic              scale_sat;
  always_comb begin
    sh      = 7'sd30 - $signed({n_q[5], n_q});
    sh_u    = sh[5:0];
    rnd     = mul_p + (64'd1 << (sh_u - 6'd1));
    scale_v = rnd >> sh_u;
    if (sh <= 7'sd0) begin
      scale_sat  = (base_q != 24'd0);
      scale_freq = scale_sat ? FMAX : 24'd0;
    end else begin
      scale_sat  = scale_v > 64'(FMAX);
      scale_freq = scale_sat ? FMAX : scale_v[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      phase_q     <= '0;
      base_q      <= '0;
      w_q         <= '0;
      s_q         <= '0;
      a_neg_q     <= 1'b0;
      a_mag_q     <= '0;
      q_q         <= '0;
      n_q         <= '0;
      fr_q        <= '0;
      y_q         <= '0;
      x_q         <= '0;
      t_q         <= '0;
      m_q         <= '0;
      k_q         <= '0;
      res_freq_q  <= '0;
      res_sat_q   <= 1'b0;
      out_valid_q <= 1'b0;
      mod_freq_q  <= '0;
      wave_out_q  <= '0;
      phase_out_q <= '0;
      sat_out_q   <= 1'b0;
    end else begin
      // the last state reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            phase_q <= phase_sum;
            acc_q   <= acc_q + PHASE_BITS'(cfg.rate_increment);
            base_q  <= base_freq_i;
            state_q <= ST_IDX;
          end
        end
        ST_IDX:  state_q <= ST_ROM;
        ST_ROM:  state_q <= ST_WAVE;
        ST_WAVE: begin
          w_q     <= wave_d;
          s_q     <= arp_step;
          state_q <= ST_DW;
        end
        ST_DW: begin
          a_neg_q <= (cfg.mod_mode == MODE_ARP) ? s_q[7] : (cfg.depth[13] ^ w_q[15]);
          state_q <= ST_DISP;
        end
        ST_DISP: begin
          a_mag_q <= mul_p[28:0];
          case (cfg.mod_mode)
            MODE_LIN: begin
              res_freq_q <= lin_freq;
              res_sat_q  <= lin_sat;
              state_q    <= ST_DONE;
            end
            MODE_EXP, MODE_ARP: state_q <= ST_DIV1;
            default: begin
              res_freq_q <= base_q;
              res_sat_q  <= 1'b0;
              state_q    <= ST_DONE;
            end
          endcase
        end
        ST_DIV1: state_q <= ST_DIV2;
        ST_DIV2: begin
          q_q     <= mul_p[63:32];
          state_q <= ST_DIV3;
        end
        ST_DIV3: begin
          n_q     <= e16[21:16];
          fr_q    <= e16[15:0];
          state_q <= ST_Y;
        end
        ST_Y:    state_q <= ST_YL;
        ST_YL: begin
          y_q     <= mul_p[45:16];
          t_q     <= 31'h4000_0000;
          m_q     <= 32'h4000_0000;
          k_q     <= '0;
          state_q <= ST_T1;
        end
        ST_T1:   state_q <= ST_T2;
        ST_T2: begin
          x_q     <= mul_p[61:30];
          state_q <= ST_T3;
        end
        ST_T3: begin
          q_q     <= mul_p[63:32];
          state_q <= ST_T4;
        end
        ST_T4: begin
          t_q <= term_q[30:0];
          m_q <= m_q + term_q;
          if (k_q == TERM_LAST) begin
            state_q <= ST_BASE;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= ST_T1;
          end
        end
        ST_BASE: state_q <= ST_SCALE;
        ST_SCALE: begin
          res_freq_q <= scale_freq;
          res_sat_q  <= scale_sat;
          state_q    <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            mod_freq_q  <= res_freq_q;
            wave_out_q  <= w_q;
            phase_out_q <= 24'(phase_q);
            sat_out_q   <= res_sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign mod_freq_o   = mod_freq_q;
  assign wave_value_o = $signed(wave_out_q);
  assign phase_now_o  = phase_out_q;
  assign saturated_o  = sat_out_q;

endmodule

### tb/tb_lfo_pitch_modulator.sv
`timescale 1ns / 100ps

module tb_lfo_pitch_modulator;
  import lpm_pkg::*;

  localparam int SINE_DEPTH  = 256;
  localparam int MAX_STEPS   = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 64;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_LN2     = 64'd744261118;

  typedef struct {
    logic [23:0]        mod_freq;
    logic signed [15:0] wave;
    logic [23:0]        phase;
    logic               sat;
  } tick_word_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [23:0]        base_freq_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [23:0]        mod_freq_o;
  logic signed [15:0] wave_value_o;
  logic [23:0]        phase_now_o;
  logic               saturated_o;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i  = '0;
  logic [63:0]        cfg_data_i   = '0;

  // predictor state
  lpm_cfg_t    lfo_regs;
  logic [23:0] lfo_phase_acc;
  int          quarter_sine [0:SINE_DEPTH];

  tick_word_t  expected_ticks [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int ticks_sent   = 0;
  int ticks_seen   = 0;
  int reg_writes   = 0;
  int mismatches   = 0;
  int stall_cycles = 0;

  lfo_pitch_modulator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .base_freq_i  (base_freq_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mod_freq_o   (mod_freq_o),
    .wave_value_o (wave_value_o),
    .phase_now_o  (phase_now_o),
    .saturated_o  (saturated_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint floor_div(input longint a, input longint d);
    if (a >= 0) begin
      return a / d;
    end
    return -((-a + d - 1) / d);
  endfunction

  // quarter wave in q15 from a taylor series in q30 with six terms after the leading x
  function automatic void build_sine_table();
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] q;
    longint      s;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x = (64'(i) * Q30_HALF_PI) / 64'(SINE_DEPTH);
      t = x;
      s = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        t = (((t * x) >> 30) * x) >> 30;
        t = t / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          s = s - longint'(t);
        end else begin
          s = s + longint'(t);
        end
      end
      if (s <= 0) begin
        quarter_sine[i] = 0;
      end else begin
        q = (64'(s) + 64'd16384) >> 15;
        quarter_sine[i] = (q > 64'd32767) ? 32767 : int'(q);
      end
    end
  endfunction

  function automatic void reset_predictor();
    lfo_regs.rate_increment = '0;
    lfo_regs.phase_offset   = '0;
    lfo_regs.waveform       = WAVE_SINE;
    lfo_regs.pulse_width    = 24'h80_0000;
    lfo_regs.mod_mode       = MODE_EXP;
    lfo_regs.depth          = '0;
    lfo_regs.arp_offsets    = '0;
    lfo_regs.arp_count      = 4'd1;
    lfo_phase_acc           = '0;
  endfunction

  function automatic void apply_reg(input lpm_cfg_idx_e idx, input logic [63:0] data);
    case (idx)
      CFG_RATE:    lfo_regs.rate_increment = data[23:0];
      CFG_OFFSET:  lfo_regs.phase_offset   = data[23:0];
      CFG_WAVE:    lfo_regs.waveform       = data[2:0];
      CFG_PULSE:   lfo_regs.pulse_width    = data[23:0];
      CFG_MODE:    lfo_regs.mod_mode       = data[1:0];
      CFG_DEPTH:   lfo_regs.depth          = data[13:0];
      CFG_ARP_OFS: lfo_regs.arp_offsets    = data;
      CFG_ARP_CNT: lfo_regs.arp_count      = data[3:0];
      default: ;
    endcase
  endfunction

  function automatic int wave_at(input logic [31:0] f);
    int          v;
    int          q;
    logic [63:0] idx;
    case (lfo_regs.waveform)
      WAVE_SINE: begin
        idx = (64'(f[29:0]) * 64'(SINE_DEPTH)) >> 30;
        v = f[30] ? quarter_sine[SINE_DEPTH - int'(idx)] : quarter_sine[int'(idx)];
        return f[31] ? -v : v;
      end
      WAVE_SAW_UP: begin
        q = f[31:16];
        return q - 32768;
      end
      WAVE_SAW_DN: begin
        q = f[31:16];
        q = 32768 - q;
        return (q > 32767) ? 32767 : q;
      end
      WAVE_TRI: begin
        q = f[31:15];
        if (q < 32768) begin
          return q;
        end
        if (q < 98304) begin
          return (65536 - q > 32767) ? 32767 : 65536 - q;
        end
        return q - 131072;
      end
      WAVE_RECT: begin
        return (64'(f) < (64'(lfo_regs.pulse_width) << 8)) ? 32767 : -32768;
      end
      default: return 0;
    endcase
  endfunction

  // base * 2^(e16 / 65536) with an exp series of ten terms after the leading one, rounded half up
  function automatic logic [63:0] pow2_scale(input logic [63:0] base, input longint e16);
    longint      n;
    longint      sh;
    logic [63:0] fr;
    logic [63:0] y;
    logic [63:0] m;
    logic [63:0] t;
    logic [63:0] prod;
    n  = floor_div(e16, 65536);
    fr = 64'(e16 - n * 65536);
    y  = (fr * Q30_LN2) >> 16;
    m  = Q30_ONE;
    t  = Q30_ONE;
    for (int k = 1; k <= 10; k++) begin
      t = ((t * y) >> 30) / 64'(k);
      m = m + t;
    end
    prod = base * m;
    sh   = 30 - n;
    if (sh > 62) begin
      return '0;
    end
    if (sh <= 0) begin
      return (base != 0) ? 64'(FMAX) + 64'd1 : 64'd0;
    end
    return (prod + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic tick_word_t predict_tick(input logic [23:0] base);
    tick_word_t  res;
    logic [23:0] p;
    logic [31:0] f;
    longint      w;
    longint      d;
    longint      r;
    longint      s;
    logic [63:0] v;
    logic [63:0] cnt;
    logic [63:0] sel;
    logic [63:0] byte_val;
    p = lfo_phase_acc + lfo_regs.phase_offset;
    f = {p, 8'h00};
    w = wave_at(f);
    d = $signed(lfo_regs.depth);
    lfo_phase_acc = lfo_phase_acc + lfo_regs.rate_increment;
    res.sat = 1'b0;
    case (lfo_regs.mod_mode)
      MODE_EXP: begin
        v = pow2_scale(64'(base), floor_div(d * w, 600));
        r = (v > 64'(FMAX)) ? longint'(FMAX) + 1 : longint'(v);
      end
      MODE_LIN: begin
        r = longint'(base) + floor_div(d * w, 128);
      end
      MODE_ARP: begin
        cnt = 64'(lfo_regs.arp_count);
        if (cnt == 0) begin
          cnt = 1;
        end
        if (cnt > MAX_STEPS) begin
          cnt = MAX_STEPS;
        end
        sel      = ((64'(f) * cnt) >> 32) & 64'd7;
        byte_val = (lfo_regs.arp_offsets >> (sel * 8)) & 64'hFF;
        s = byte_val[7] ? longint'(byte_val) - 256 : longint'(byte_val);
        v = pow2_scale(64'(base), floor_div(s * 65536, 12));
        r = (v > 64'(FMAX)) ? longint'(FMAX) + 1 : longint'(v);
      end
      default: r = longint'(base);
    endcase
    if (r < 0) begin
      r = 0;
      res.sat = 1'b1;
    end else if (r > longint'(FMAX)) begin
      r = longint'(FMAX);
      res.sat = 1'b1;
    end
    res.mod_freq = r[23:0];
    res.wave     = w[15:0];
    res.phase    = p;
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  // lower valid and wait until every expected word has come back
  task automatic settle();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
    end
    while (expected_ticks.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input lpm_cfg_idx_e idx, input logic [63:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    apply_reg(idx, data);
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tick(input logic [23:0] base);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    base_freq_i <= base;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    expected_ticks.push_back(predict_tick(base));
    ticks_sent++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    tick_word_t exp_word;
    if (rst_ni && out_valid_o && out_ready_i) begin
      ticks_seen++;
      if (expected_ticks.size() == 0) begin
        $error("result word with nothing expected: mod_freq %0d", mod_freq_o);
        mismatches++;
      end else begin
        exp_word = expected_ticks.pop_front();
        if (mod_freq_o !== exp_word.mod_freq) begin
          $error("mod_freq: expected %0d, got %0d", exp_word.mod_freq, mod_freq_o);
          mismatches++;
        end
        if (wave_value_o !== exp_word.wave) begin
          $error("wave_value: expected %0d, got %0d", exp_word.wave, wave_value_o);
          mismatches++;
        end
        if (phase_now_o !== exp_word.phase) begin
          $error("phase_now: expected %0d, got %0d", exp_word.phase, phase_now_o);
          mismatches++;
        end
        if (saturated_o !== exp_word.sat) begin
          $error("saturated: expected %0d, got %0d", exp_word.sat, saturated_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_tick(24'h00_0000);
    send_tick(24'hFF_FFFF);
  endtask

  task automatic test_waveform_codes();
    write_reg(CFG_MODE, 64'(MODE_LIN));
    write_reg(CFG_DEPTH, 64'd4800);
    write_reg(CFG_RATE, 64'h2A_AAAB);
    // includes the unused codes, which give a flat wave
    for (int c = 0; c < 8; c++) begin
      write_reg(CFG_WAVE, 64'(c));
      send_tick(24'h10_0000);
    end
    write_reg(CFG_WAVE, 64'(WAVE_RECT));
    write_reg(CFG_OFFSET, 64'hFF_FFFF);
    write_reg(CFG_PULSE, 64'h00_0000);
    send_tick(24'h10_0000);
    write_reg(CFG_PULSE, 64'hFF_FFFF);
    send_tick(24'h10_0000);
  endtask

  task automatic test_mod_modes();
    write_reg(CFG_OFFSET, 64'd0);
    write_reg(CFG_RATE, 64'd0);
    write_reg(CFG_MODE, 64'(MODE_EXP));
    write_reg(CFG_DEPTH, 64'h1FFF);
    send_tick(24'hFF_FFFF);
    send_tick(24'h00_0001);
    write_reg(CFG_DEPTH, 64'h2000);
    send_tick(24'hFF_FFFF);
    write_reg(CFG_MODE, 64'(MODE_LIN));
    send_tick(24'h00_0064);
    write_reg(CFG_DEPTH, 64'h1FFF);
    send_tick(24'hFF_FFF0);
    // unused mode code passes the base through
    write_reg(CFG_MODE, 64'd3);
    send_tick(24'h12_3456);
    write_reg(CFG_MODE, 64'(MODE_ARP));
    write_reg(CFG_ARP_OFS, 64'h807F_0C00_F4E8_1801);
    write_reg(CFG_RATE, 64'h12_3457);
    write_reg(CFG_ARP_CNT, 64'd0);
    send_tick(24'h01_B800);
    write_reg(CFG_ARP_CNT, 64'd15);
    send_tick(24'h01_B800);
    send_tick(24'hFF_FFFF);
    write_reg(CFG_ARP_CNT, 64'd8);
    send_tick(24'h00_0001);
  endtask

  function automatic logic [23:0] pick_base();
    case ($urandom_range(0, 9))
      0:       return 24'h00_0000;
      1:       return 24'hFF_FFFF;
      2:       return 24'($urandom_range(1, 255));
      3, 4:    return 24'($urandom_range(2000, 600000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_span();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return 64'hFF_FFFF;
      2:       return 64'($urandom_range(1, 4096));
      default: return 64'($urandom & 32'hFF_FFFF);
    endcase
  endfunction

  task automatic randomize_regs();
    int          code;
    int          dep;
    logic [63:0] ofs;
    write_reg(CFG_RATE, pick_span());
    write_reg(CFG_OFFSET, pick_span());
    code = $urandom_range(0, 11);
    if (code > 7) begin
      code = $urandom_range(0, 4);
    end
    write_reg(CFG_WAVE, 64'(code));
    write_reg(CFG_PULSE, pick_span());
    code = $urandom_range(0, 6);
    if (code > 3) begin
      code = $urandom_range(0, 2);
    end
    write_reg(CFG_MODE, 64'(code));
    case ($urandom_range(0, 9))
      0:       dep = -4800;
      1:       dep = 4800;
      2:       dep = -8192;
      3:       dep = 8191;
      default: dep = int'($urandom_range(0, 9600)) - 4800;
    endcase
    write_reg(CFG_DEPTH, 64'(dep[13:0]));
    if ($urandom_range(0, 1) == 1) begin
      ofs = {$urandom, $urandom};
    end else begin
      // musical offsets within two octaves
      for (int i = 0; i < 8; i++) begin
        dep = int'($urandom_range(0, 48)) - 24;
        ofs[i*8 +: 8] = dep[7:0];
      end
    end
    write_reg(CFG_ARP_OFS, ofs);
    code = $urandom_range(0, 19);
    if (code > 15) begin
      code = $urandom_range(1, 8);
    end
    write_reg(CFG_ARP_CNT, 64'(code));
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_ticks);
    int sent;
    int batch;
    sent = 0;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    while (sent < n_ticks) begin
      randomize_regs();
      batch = $urandom_range(30, 70);
      for (int i = 0; i < batch; i++) begin
        send_tick(pick_base());
      end
      sent += batch;
    end
    settle();
  endtask

  initial begin
    build_sine_table();
    reset_predictor();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_waveform_codes();
    test_mod_modes();
    settle();

    test_random_traffic(18, 88, 600);
    test_random_traffic(88, 18, 600);
    test_random_traffic(0, 0, 600);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("sent %0d ticks, checked %0d result words, %0d register writes",
             ticks_sent, ticks_seen, reg_writes);
    $display("all waveform and mode codes, saturation both ways, three idle patterns");
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/lpm_pkg.sv
design/lpm_cfg_regs.sv
design/lpm_mul.sv
design/lpm_sine_rom.sv
design/lfo_pitch_modulator.sv
tb/tb_lfo_pitch_modulator.sv
